### sv/lqck_pkg.sv
`timescale 1ns / 1ps

package lqck_pkg;

  localparam int CMD_W  = 3;
  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_CHECK  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SCAN,
    DP_SHIFT,
    DP_RD_FRONT,
    DP_RD_REAR,
    DP_FINISH
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RD_FRONT,
    S_RD_REAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic need_scan;
    logic hit;
    logic scan_end;
    logic is_cancel;
    logic shift_end;
    logic out_free;
  } dp_stat_t;

endpackage

### sv/lqck_cmd_if.sv
`timescale 1ns / 1ps

interface lqck_cmd_if import lqck_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink (input valid, input cmd, input key, output ready);
endinterface

### sv/lqck_res_if.sv
`timescale 1ns / 1ps

interface lqck_res_if import lqck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [OCC_W-1:0]  occupancy;
  logic [KEY_W-1:0]  front_key;
  logic [KEY_W-1:0]  rear_key;
  logic              is_empty;
  logic              is_full;

  modport source (
    output valid, output status, output found, output occupancy,
    output front_key, output rear_key, output is_empty, output is_full,
    input ready
  );
  modport sink (
    input valid, input status, input found, input occupancy,
    input front_key, input rear_key, input is_empty, input is_full,
    output ready
  );
endinterface

### sv/lqck_dp.sv
`timescale 1ns / 1ps

module lqck_dp import lqck_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  output dp_stat_t          stat_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic              found_o,
  output logic [OCC_W-1:0]  occupancy_o,
  output logic [KEY_W-1:0]  front_key_o,
  output logic [KEY_W-1:0]  rear_key_o,
  output logic              is_empty_o,
  output logic              is_full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_BITS-1:0] mem [DEPTH];

  logic [CW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] ptr_q, ptr_d, ra_q, ra_d, wa_q, wa_d;
  logic [CW-1:0] tail_m1;
  logic          rv_q, rv_d, cancel_q, cancel_d, out_vld_q, out_vld_d;
  logic          found_q, found_d;
  stat_e         stat_q, stat_d;
  logic [KEY_BITS-1:0] key_q, key_d, key_in, rdata_q, front_q, front_d, wdata;

  logic          ren, wen;
  logic [AW-1:0] raddr, waddr;

  logic [63:0] key_wide, front_wide, rear_wide;
  logic [31:0] occ_wide;
  logic        empty, full, ptr_lt, hit, out_free, load_res;
  cmd_e        cmd;

  logic [STAT_W-1:0] res_status_q;
  logic              res_found_q, res_empty_q, res_full_q;
  logic [OCC_W-1:0]  res_occ_q;
  logic [KEY_W-1:0]  res_front_q, res_rear_q;

  assign key_wide   = 64'(key_i);
  assign key_in     = key_wide[KEY_BITS-1:0];
  assign front_wide = 64'(front_q);
  assign rear_wide  = 64'(rdata_q);
  assign occ_wide   = 32'(tail_q - head_q);
  assign tail_m1    = tail_q - CW'(1);

  assign cmd      = cmd_e'(cmd_i);
  assign empty    = head_q == tail_q;
  assign full     = tail_q == CW'(DEPTH);
  assign ptr_lt   = ptr_q < tail_q;
  assign hit      = rv_q && (rdata_q == key_q);
  assign out_free = !out_vld_q || out_ready_i;
  assign load_res = (op_i == DP_FINISH) && out_free;

  assign stat_o.need_scan = ((cmd == CMD_CANCEL) || (cmd == CMD_CHECK)) && !empty;
  assign stat_o.hit       = hit;
  assign stat_o.scan_end  = !rv_q && !ptr_lt;
  assign stat_o.is_cancel = cancel_q;
  assign stat_o.shift_end = !rv_q && !ptr_lt;
  assign stat_o.out_free  = out_free;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    ptr_d     = ptr_q;
    ra_d      = ra_q;
    wa_d      = wa_q;
    rv_d      = rv_q;
    cancel_d  = cancel_q;
    found_d   = found_q;
    stat_d    = stat_q;
    key_d     = key_q;
    front_d   = front_q;
    out_vld_d = out_vld_q && !out_ready_i;
    ren       = 1'b0;
    raddr     = ptr_q[AW-1:0];
    wen       = 1'b0;
    waddr     = wa_q[AW-1:0];
    wdata     = rdata_q;
    case (op_i)
      DP_LOAD: begin
        key_d    = key_in;
        cancel_d = cmd == CMD_CANCEL;
        stat_d   = STAT_OK;
        found_d  = 1'b0;
        ptr_d    = head_q;
        rv_d     = 1'b0;
        case (cmd)
          CMD_ENQ: begin
            if (full) begin
              stat_d = STAT_OVERFLOW;
            end else begin
              wen    = 1'b1;
              waddr  = tail_q[AW-1:0];
              wdata  = key_in;
              tail_d = tail_q + CW'(1);
            end
          end
          CMD_DEQ: begin
            if (empty) begin
              stat_d = STAT_EMPTY;
            end else begin
              head_d = head_q + CW'(1);
            end
          end
          CMD_CANCEL, CMD_CHECK: begin
            if (empty) begin
              stat_d = STAT_NOT_FOUND;
            end
          end
          CMD_CLEAR: begin
            head_d = '0;
            tail_d = '0;
          end
          default: ;
        endcase
      end
      DP_SCAN: begin
        if (hit) begin
          found_d = 1'b1;
          ptr_d   = ra_q + CW'(1);
          wa_d    = ra_q;
          rv_d    = 1'b0;
        end else if (!rv_q && !ptr_lt) begin
          stat_d = STAT_NOT_FOUND;
        end else begin
          ren  = ptr_lt;
          rv_d = ptr_lt;
          ra_d = ptr_q;
          if (ptr_lt) begin
            ptr_d = ptr_q + CW'(1);
          end
        end
      end
      DP_SHIFT: begin
        // move each later entry down one slot, reads run one ahead of writes
        if (rv_q) begin
          wen  = 1'b1;
          wa_d = wa_q + CW'(1);
        end
        ren  = ptr_lt;
        rv_d = ptr_lt;
        if (ptr_lt) begin
          ptr_d = ptr_q + CW'(1);
        end
        if (!rv_q && !ptr_lt) begin
          tail_d = tail_m1;
        end
      end
      DP_RD_FRONT: begin
        ren   = 1'b1;
        raddr = head_q[AW-1:0];
      end
      DP_RD_REAR: begin
        front_d = rdata_q;
        ren     = 1'b1;
        raddr   = tail_m1[AW-1:0];
      end
      DP_FINISH: begin
        if (out_free) begin
          out_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      rv_q      <= rv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    ra_q     <= ra_d;
    wa_q     <= wa_d;
    cancel_q <= cancel_d;
    found_q  <= found_d;
    stat_q   <= stat_d;
    key_q    <= key_d;
    front_q  <= front_d;
    if (load_res) begin
      res_status_q <= stat_q;
      res_found_q  <= found_q;
      res_occ_q    <= occ_wide[OCC_W-1:0];
      res_front_q  <= empty ? '0 : front_wide[KEY_W-1:0];
      res_rear_q   <= empty ? '0 : rear_wide[KEY_W-1:0];
      res_empty_q  <= empty;
      res_full_q   <= full;
    end
  end

  // slot store
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = res_status_q;
  assign found_o     = res_found_q;
  assign occupancy_o = res_occ_q;
  assign front_key_o = res_front_q;
  assign rear_key_o  = res_rear_q;
  assign is_empty_o  = res_empty_q;
  assign is_full_o   = res_full_q;

`ifndef ASSERT_OFF
  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("head index passed tail");

  a_tail_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CW'(DEPTH))
    else $error("tail beyond last slot");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DP_SHIFT && rv_q) |-> (wa_q < ptr_q && ptr_q <= tail_q))
    else $error("shift write overtook read");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DP_SCAN && hit) |-> (ra_q >= head_q && ra_q < tail_q))
    else $error("match outside queued entries");
`endif

endmodule

### sv/lqck_ctrl.sv
`timescale 1ns / 1ps

module lqck_ctrl import lqck_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = DP_IDLE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = DP_LOAD;
          state_d = stat_i.need_scan ? S_SCAN : S_RD_FRONT;
        end
      end
      S_SCAN: begin
        op_o = DP_SCAN;
        if (stat_i.hit) begin
          state_d = stat_i.is_cancel ? S_SHIFT : S_RD_FRONT;
        end else if (stat_i.scan_end) begin
          state_d = S_RD_FRONT;
        end
      end
      S_SHIFT: begin
        op_o = DP_SHIFT;
        if (stat_i.shift_end) begin
          state_d = S_RD_FRONT;
        end
      end
      S_RD_FRONT: begin
        op_o    = DP_RD_FRONT;
        state_d = S_RD_REAR;
      end
      S_RD_REAR: begin
        op_o    = DP_RD_REAR;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        op_o = DP_FINISH;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/linear_queue_with_cancel_by_key.sv
// Linear array queue of keys with enqueue, dequeue, cancel by key, check and
// clear; each command word gives one result word with status, match flag,
// occupancy, front and rear keys. One command is handled at a time; the
// slot memory has one registered read port, so the front and rear keys of a
// result are read one after the other. Enqueue, dequeue, clear and refused
// commands need no scan. Check scans entries from the head until a key
// matches or none is left; cancel adds that scan and, after a match, shifts
// each later entry down one slot. A new command is taken while the last
// result still waits on the output. No clearing pass follows reset.
`timescale 1ns / 1ps

module linear_queue_with_cancel_by_key import lqck_pkg::*; #(
  parameter int DEPTH    = 256,
  parameter int KEY_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lqck_cmd_if.sink     in_i,
  lqck_res_if.source   out_o
);

  dp_stat_t dp_stat;
  dp_op_e   dp_op;
  logic     in_ready;

  lqck_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .op_o       (dp_op)
  );

  lqck_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (dp_op),
    .stat_o      (dp_stat),
    .cmd_i       (in_i.cmd),
    .key_i       (in_i.key),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .found_o     (out_o.found),
    .occupancy_o (out_o.occupancy),
    .front_key_o (out_o.front_key),
    .rear_key_o  (out_o.rear_key),
    .is_empty_o  (out_o.is_empty),
    .is_full_o   (out_o.is_full)
  );

  assign in_i.ready = in_ready;

endmodule

### dv/linear_queue_with_cancel_by_key_tb.sv
`timescale 1ns / 1ps

module linear_queue_with_cancel_by_key_tb;
  import lqck_pkg::*;

  localparam int DEPTH    = 256;
  localparam int KEY_BITS = 32;
  localparam int N_WORDS  = 1170;
  localparam int N_DIR    = 22;
  localparam int N_POOL   = 8;
  localparam int HOLD_CYC = 300;
  localparam int DRAIN_CYC = 2 * DEPTH + 16;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    stat_e            status;
    logic             found;
    logic [OCC_W-1:0] occupancy;
    logic [KEY_W-1:0] front_key;
    logic [KEY_W-1:0] rear_key;
    logic             is_empty;
    logic             is_full;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               typed_res;
    result_t          res;
  } stim_row_t;

  localparam result_t RES_DEQ_EMPTY = '{STAT_EMPTY, 1'b0, '0, '0, '0, 1'b1, 1'b0};
  localparam result_t RES_NF_EMPTY  = '{STAT_NOT_FOUND, 1'b0, '0, '0, '0, 1'b1, 1'b0};
  localparam result_t RES_CLEARED   = '{STAT_OK, 1'b0, '0, '0, '0, 1'b1, 1'b0};

  logic clk_i;
  logic rst_ni;

  lqck_cmd_if cmd_if ();
  lqck_res_if res_if ();

  linear_queue_with_cancel_by_key #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // queue shadow
  logic [KEY_W-1:0] slot_mem [DEPTH];
  int               head_idx = 0;
  int               tail_idx = 0;

  result_t   pending_res [$];
  stim_row_t dir_tab [N_DIR];
  logic [KEY_W-1:0] key_pool [N_POOL] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                          32'h8000_0000, 32'hDEAD_BEEF, 32'h5A5A_5A5A,
                                          32'h0000_0007, 32'h0000_FFFF};

  int mismatches    = 0;
  int words_sent    = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 50;
  int hold_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t apply_word(input logic [CMD_W-1:0] c,
                                         input logic [KEY_W-1:0] k);
    result_t r;
    int      pos;
    r = '0;
    r.status = STAT_OK;
    pos = -1;
    case (c)
      CMD_ENQ: begin
        if (tail_idx >= DEPTH) begin
          r.status = STAT_OVERFLOW;
        end else begin
          slot_mem[tail_idx] = k;
          tail_idx++;
        end
      end
      CMD_DEQ: begin
        if (head_idx >= tail_idx) r.status = STAT_EMPTY;
        else head_idx++;
      end
      CMD_CANCEL, CMD_CHECK: begin
        for (int i = head_idx; i < tail_idx; i++)
          if (pos < 0 && slot_mem[i] == k) pos = i;
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          if (c == CMD_CANCEL) begin
            for (int i = pos; i + 1 < tail_idx; i++) slot_mem[i] = slot_mem[i + 1];
            tail_idx--;
          end
        end
      end
      CMD_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
      end
      default: ;
    endcase
    r.is_empty = (head_idx >= tail_idx);
    r.is_full  = (tail_idx >= DEPTH);
    if (!r.is_empty) begin
      r.occupancy = OCC_W'(tail_idx - head_idx);
      r.front_key = slot_mem[head_idx];
      r.rear_key  = slot_mem[tail_idx - 1];
    end
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input bit from_queue);
    if (from_queue && tail_idx > head_idx && $urandom_range(99) < 70)
      return slot_mem[$urandom_range(tail_idx - 1, head_idx)];
    if ($urandom_range(99) < 40) return key_pool[$urandom_range(N_POOL - 1)];
    return $urandom;
  endfunction

  // drive one command word and record its result once accepted
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input bit typed_res, input result_t res);
    result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= c;
    cmd_if.key   <= k;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    want = apply_word(c, k);
    pending_res.push_back(typed_res ? res : want);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_word();
    int               r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(99);
    if (r < 40) c = CMD_ENQ;
    else if (r < 55) c = CMD_DEQ;
    else if (r < 73) c = CMD_CANCEL;
    else if (r < 93) c = CMD_CHECK;
    else if (r < 96) c = CMD_CLEAR;
    else c = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    send_word(c, pick_key(c == CMD_CANCEL || c == CMD_CHECK), 1'b0, '0);
  endtask

  task automatic wait_all_results();
    while (pending_res.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result side
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t unexpected result word: expected none actual status %0d occ %0d",
                 $time, res_if.status, res_if.occupancy);
        mismatches++;
      end else begin
        want = pending_res.pop_front();
        compare_field("status", KEY_W'(want.status), KEY_W'(res_if.status));
        compare_field("found", KEY_W'(want.found), KEY_W'(res_if.found));
        compare_field("occupancy", KEY_W'(want.occupancy), KEY_W'(res_if.occupancy));
        compare_field("front_key", want.front_key, res_if.front_key);
        compare_field("rear_key", want.rear_key, res_if.rear_key);
        compare_field("is_empty", KEY_W'(want.is_empty), KEY_W'(res_if.is_empty));
        compare_field("is_full", KEY_W'(want.is_full), KEY_W'(res_if.is_full));
      end
    end
  end

  initial begin
    #25_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase;
    int r;
    phase = 0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = CMD_ENQ;
    cmd_if.key   = '0;

    dir_tab = '{
      '{CMD_DEQ,     32'h0000_0000, 1'b1, RES_DEQ_EMPTY},
      '{CMD_CHECK,   32'h0000_0000, 1'b1, RES_NF_EMPTY},
      '{CMD_CANCEL,  32'hFFFF_FFFF, 1'b1, RES_NF_EMPTY},
      '{CMD_ENQ,     32'h0000_0000, 1'b1,
        '{STAT_OK, 1'b0, 9'd1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}},
      '{CMD_ENQ,     32'hFFFF_FFFF, 1'b1,
        '{STAT_OK, 1'b0, 9'd2, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0}},
      '{CMD_ENQ,     32'h5555_5555, 1'b0, '0},
      '{CMD_ENQ,     32'hAAAA_AAAA, 1'b0, '0},
      '{CMD_ENQ,     32'hFFFF_FFFF, 1'b0, '0},
      '{CMD_CHECK,   32'hFFFF_FFFF, 1'b0, '0},
      '{CMD_CANCEL,  32'hFFFF_FFFF, 1'b0, '0},
      '{CMD_CHECK,   32'h0000_1234, 1'b0, '0},
      '{CMD_CANCEL,  32'h0000_0000, 1'b0, '0},
      '{CMD_CANCEL,  32'hFFFF_FFFF, 1'b0, '0},
      '{CMD_CANCEL,  32'h0000_0001, 1'b0, '0},
      '{CMD_DEQ,     32'h0000_0000, 1'b0, '0},
      '{CMD_DEQ,     32'h0000_0000, 1'b0, '0},
      '{CMD_DEQ,     32'h0000_0000, 1'b1, RES_DEQ_EMPTY},
      '{CMD_ENQ,     32'h8000_0001, 1'b0, '0},
      '{CMD_RSVD_LO, 32'h1234_5678, 1'b0, '0},
      '{CMD_RSVD_HI, 32'hFFFF_FFFF, 1'b0, '0},
      '{CMD_CLEAR,   32'h0000_0000, 1'b1, RES_CLEARED},
      '{CMD_CHECK,   32'h8000_0001, 1'b1, RES_NF_EMPTY}
    };

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].key, dir_tab[i].typed_res, dir_tab[i].res);

    // output held off while command words keep coming
    hold_cycles = HOLD_CYC;

    while (words_sent < N_WORDS) begin
      if (phase == 0 && words_sent >= N_WORDS / 3) begin
        cmd_if.valid <= 1'b0;
        wait_all_results();
        send_idle_pct = 50;
        recv_idle_pct = 28;
        phase = 1;
      end else if (phase == 1 && words_sent >= 2 * N_WORDS / 3) begin
        cmd_if.valid <= 1'b0;
        wait_all_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        repeat ($urandom_range(40, 10)) random_word();
      end else if (r < 80) begin
        // fill to the last slot, then push past it
        while (tail_idx < DEPTH) send_word(CMD_ENQ, pick_key(1'b0), 1'b0, '0);
        repeat ($urandom_range(3, 1)) send_word(CMD_ENQ, pick_key(1'b0), 1'b0, '0);
        repeat ($urandom_range(8, 1)) random_word();
      end else begin
        while (tail_idx > head_idx) send_word(CMD_DEQ, pick_key(1'b0), 1'b0, '0);
        repeat ($urandom_range(2, 1)) send_word(CMD_DEQ, pick_key(1'b0), 1'b0, '0);
        repeat ($urandom_range(6, 1)) random_word();
      end
    end

    cmd_if.valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/lqck_pkg.sv
sv/lqck_cmd_if.sv
sv/lqck_res_if.sv
sv/lqck_dp.sv
sv/lqck_ctrl.sv
sv/linear_queue_with_cancel_by_key.sv
dv/linear_queue_with_cancel_by_key_tb.sv
